>>> hdl/b2da_pkg.sv
// Shared types and constants for the binary to decimal ASCII converter.
// Holds the request and text payload structs and the digit sizing helpers.
// No dependencies.
package b2da_pkg;

	localparam int FIELD_BITS = 32;
	localparam int DIGIT_BITS = 4;
	localparam int BITS_PER_STEP = 4;

	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	localparam logic [DIGIT_BITS-1:0] BCD_ADJ_MIN = 4'd5;
	localparam logic [DIGIT_BITS-1:0] BCD_ADJ = 4'd3;

	typedef struct packed {
		logic [FIELD_BITS-1:0] value;
		logic                  is_signed;
	} req_t;

	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} txt_t;

	// Upper bound on the decimal digits of an unsigned word of the given width.
	function automatic int digit_count(input int bits);
		return (bits * 1233) / 4096 + 1;
	endfunction

	// Word width rounded up to whole conversion steps.
	function automatic int pad_bits(input int bits);
		return ((bits + BITS_PER_STEP - 1) / BITS_PER_STEP) * BITS_PER_STEP;
	endfunction

endpackage

>>> hdl/b2da_front.sv
// Front end of the converter: accepts requests, masks the word and takes its magnitude.
// Depends on b2da_pkg.
module b2da_front #(
	parameter int VALUE_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  b2da_pkg::req_t      req,
	output logic                push,
	input  logic                full,
	output logic [VALUE_BITS:0] push_data
);
	import b2da_pkg::*;

	logic [VALUE_BITS-1:0] word;
	logic [VALUE_BITS-1:0] mag;
	logic                  neg;
	logic                  accept;
	logic                  valid_s1;
	logic [VALUE_BITS:0]   data_s1;

	generate
		if (VALUE_BITS <= FIELD_BITS) begin : g_narrow
			assign word = req.value[VALUE_BITS-1:0];
		end else begin : g_wide
			assign word = VALUE_BITS'(req.value);
		end
	endgenerate

	// The most negative value wraps to its own bit pattern, which read unsigned is exact.
	assign neg = req.is_signed & word[VALUE_BITS-1];
	assign mag = neg ? (~word + 1'b1) : word;

	assign push      = valid_s1 & ~full;
	assign req_stall = valid_s1 & full;
	assign accept    = req_valid & ~req_stall;
	assign push_data = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= {neg, mag};
		end
	end

endmodule

>>> hdl/b2da_queue.sv
// Two-entry queue that decouples the front end from the conversion unit.
// Depends on nothing but its width parameter.
module b2da_queue #(
	parameter int WIDTH = 33
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);
	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = push & ~full;
	assign do_pop   = pop & ~empty;
	assign pop_data = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= PTR_W'(wr_q + 1'b1);
			end
			if (do_pop) begin
				rd_q <= PTR_W'(rd_q + 1'b1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= CNT_W'(cnt_q + 1'b1);
				2'b01:   cnt_q <= CNT_W'(cnt_q - 1'b1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_data;
		end
	end

endmodule

>>> hdl/b2da_convert.sv
// Conversion unit: shift-and-add-three binary to BCD, four bits per cycle.
// Depends on b2da_pkg.
module b2da_convert #(
	parameter int VALUE_BITS = 32,
	localparam int DIGITS = b2da_pkg::digit_count(VALUE_BITS)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [VALUE_BITS:0]      q_data,
	input  logic                     q_empty,
	output logic                     q_pop,
	output logic                     bcd_valid,
	input  logic                     bcd_take,
	output logic [DIGITS*4-1:0]      bcd,
	output logic                     neg
);
	import b2da_pkg::*;

	localparam int PAD_BITS = pad_bits(VALUE_BITS);
	localparam int STEPS = PAD_BITS / BITS_PER_STEP;
	localparam int CNT_W = $clog2(STEPS);
	localparam int BCD_W = DIGITS * DIGIT_BITS;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_DONE
	} state_t;

	state_t              state_q;
	logic [PAD_BITS-1:0] bin_q;
	logic [BCD_W-1:0]    bcd_q;
	logic                neg_q;
	logic [CNT_W-1:0]    step_q;
	logic [PAD_BITS-1:0] bin_nx;
	logic [BCD_W-1:0]    bcd_nx;
	logic                load;

	// Four dependent shift steps; each digit is corrected on its own before the shift.
	always_comb begin
		bcd_nx = bcd_q;
		bin_nx = bin_q;
		for (int s = 0; s < BITS_PER_STEP; s++) begin
			for (int d = 0; d < DIGITS; d++) begin
				if (bcd_nx[d*DIGIT_BITS +: DIGIT_BITS] >= BCD_ADJ_MIN) begin
					bcd_nx[d*DIGIT_BITS +: DIGIT_BITS] =
						bcd_nx[d*DIGIT_BITS +: DIGIT_BITS] + BCD_ADJ;
				end
			end
			bcd_nx = {bcd_nx[BCD_W-2:0], bin_nx[PAD_BITS-1]};
			bin_nx = {bin_nx[PAD_BITS-2:0], 1'b0};
		end
	end

	assign load      = ~q_empty & ((state_q == S_IDLE) | ((state_q == S_DONE) & bcd_take));
	assign q_pop     = load;
	assign bcd_valid = (state_q == S_DONE);
	assign bcd       = bcd_q;
	assign neg       = neg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			bin_q   <= '0;
			bcd_q   <= '0;
			neg_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (load) begin
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					bin_q  <= bin_nx;
					bcd_q  <= bcd_nx;
					step_q <= CNT_W'(step_q + 1'b1);
					if (step_q == CNT_W'(STEPS - 1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (bcd_take) begin
						state_q <= load ? S_RUN : S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (load) begin
				bin_q  <= PAD_BITS'(q_data[VALUE_BITS-1:0]);
				neg_q  <= q_data[VALUE_BITS];
				bcd_q  <= '0;
				step_q <= '0;
			end
		end
	end

endmodule

>>> hdl/b2da_emit.sv
// Character emitter: walks the BCD digits from the top, drops leading zeros, adds the sign.
// Depends on b2da_pkg.
module b2da_emit #(
	parameter int VALUE_BITS = 32,
	localparam int DIGITS = b2da_pkg::digit_count(VALUE_BITS)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 bcd_valid,
	output logic                 bcd_take,
	input  logic [DIGITS*4-1:0]  bcd,
	input  logic                 neg,
	output logic                 txt_valid,
	input  logic                 txt_stall,
	output b2da_pkg::txt_t       txt
);
	import b2da_pkg::*;

	localparam int BCD_W = DIGITS * DIGIT_BITS;
	localparam int REM_W = $clog2(DIGITS + 1);

	typedef enum logic [1:0] {
		E_IDLE,
		E_SIGN,
		E_DIGITS
	} state_t;

	state_t                state_q;
	logic [BCD_W-1:0]      digits_q;
	logic [REM_W-1:0]      rem_q;
	logic                  started_q;
	logic                  out_valid_q;
	txt_t                  out_q;
	logic                  adv;
	logic [DIGIT_BITS-1:0] top;
	logic                  is_last;
	logic                  show;

	assign adv      = ~out_valid_q | ~txt_stall;
	assign bcd_take = (state_q == E_IDLE);
	assign top      = digits_q[BCD_W-1 -: DIGIT_BITS];
	assign is_last  = (rem_q == REM_W'(1));
	assign show     = started_q | (top != '0) | is_last;

	assign txt_valid = out_valid_q;
	assign txt       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= E_IDLE;
			digits_q    <= '0;
			rem_q       <= '0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			unique case (state_q)
				E_IDLE: begin
					if (adv) begin
						out_valid_q <= 1'b0;
					end
					if (bcd_valid) begin
						digits_q  <= bcd;
						rem_q     <= REM_W'(DIGITS);
						started_q <= 1'b0;
						state_q   <= neg ? E_SIGN : E_DIGITS;
					end
				end
				E_SIGN: begin
					if (adv) begin
						out_valid_q     <= 1'b1;
						out_q.character <= CH_MINUS;
						out_q.last      <= 1'b0;
						state_q         <= E_DIGITS;
					end
				end
				E_DIGITS: begin
					if (adv) begin
						out_valid_q <= show;
						if (show) begin
							out_q.character <= CH_ZERO + 8'(top);
							out_q.last      <= is_last;
							started_q       <= 1'b1;
						end
						digits_q <= {digits_q[BCD_W-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
						rem_q    <= REM_W'(rem_q - 1'b1);
						if (is_last) begin
							state_q <= E_IDLE;
						end
					end
				end
				default: begin
					if (adv) begin
						out_valid_q <= 1'b0;
					end
					state_q <= E_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hdl/binary_to_decimal_ascii.sv
// Binary to decimal ASCII converter, top level. An accepted request is registered in the
// front end, queued, converted to BCD and then sent one character at a time by the emitter.
// The emitter steps through every digit position, leading zeros included, and so sets the
// throughput; the front end and the queue take further requests while it is busy, until full.
// arst_n clears all control state at once. Depends on b2da_pkg and the four submodules.
module binary_to_decimal_ascii #(
	parameter int VALUE_BITS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  b2da_pkg::req_t req,
	output logic           txt_valid,
	input  logic           txt_stall,
	output b2da_pkg::txt_t txt
);
	import b2da_pkg::*;

	localparam int DIGITS = digit_count(VALUE_BITS);

	// Queue traffic: a sign flag above the magnitude.
	logic                  push;
	logic                  full;
	logic [VALUE_BITS:0]   push_data;
	logic                  pop;
	logic                  empty;
	logic [VALUE_BITS:0]   pop_data;

	// Hand-off of a finished BCD word from the conversion unit to the emitter.
	logic                  bcd_valid;
	logic                  bcd_take;
	logic [DIGITS*4-1:0]   bcd;
	logic                  neg;

	// The front end takes a request, keeps only the low VALUE_BITS bits and, for a negative
	// signed word, replaces it by its magnitude. The most negative value needs no special
	// handling, as its negation read as unsigned is exactly its magnitude.
	b2da_front #(
		.VALUE_BITS (VALUE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.push      (push),
		.full      (full),
		.push_data (push_data)
	);

	// A short queue lets the front end keep taking requests while the back end is busy.
	b2da_queue #(
		.WIDTH (VALUE_BITS + 1)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	// The conversion unit runs shift-and-add-three four bits at a time and holds the BCD
	// result until the emitter is free, so it can start on the next magnitude straight away.
	b2da_convert #(
		.VALUE_BITS (VALUE_BITS)
	) u_convert (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_data    (pop_data),
		.q_empty   (empty),
		.q_pop     (pop),
		.bcd_valid (bcd_valid),
		.bcd_take  (bcd_take),
		.bcd       (bcd),
		.neg       (neg)
	);

	// The emitter sends an optional minus sign and then the digits, most significant first.
	// Leading zeros are dropped, but the units digit is always sent, so zero gives a lone '0'.
	// Its output register holds the current character while it stalls; the next one is prepared only as it is taken.
	b2da_emit #(
		.VALUE_BITS (VALUE_BITS)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.bcd_valid (bcd_valid),
		.bcd_take  (bcd_take),
		.bcd       (bcd),
		.neg       (neg),
		.txt_valid (txt_valid),
		.txt_stall (txt_stall),
		.txt       (txt)
	);

endmodule

>>> hdl/b2da_checker.sv
// Port-level checks for binary_to_decimal_ascii, attached by the bind statement at the end.
// Depends on b2da_pkg.
module b2da_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           txt_valid,
	input logic           txt_stall,
	input b2da_pkg::txt_t txt
);
	import b2da_pkg::*;

	// A character held back by the receiver stays put.
	a_txt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		txt_valid && txt_stall |=> txt_valid && $stable(txt))
		else $error("character changed while stalled");

	// Only a minus sign or a decimal digit ever leaves the block.
	a_charset: assert property (@(posedge clk) disable iff (!arst_n)
		txt_valid |-> (txt.character == CH_MINUS) ||
			(txt.character >= CH_ZERO && txt.character <= CH_NINE))
		else $error("character outside the decimal set");

	// A sign is never the end of a number.
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		txt_valid && txt.character == CH_MINUS |-> !txt.last)
		else $error("minus sign marked as last");

	// Straight after a sign comes neither another sign nor a leading zero.
	a_after_sign: assert property (@(posedge clk) disable iff (!arst_n)
		txt_valid && !txt_stall && txt.character == CH_MINUS |=>
			!txt_valid || (txt.character != CH_MINUS && txt.character != CH_ZERO))
		else $error("bad character after minus sign");

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker (.*);

>>> tb/sv/binary_to_decimal_ascii_tb.sv
// Self-checking testbench for binary_to_decimal_ascii: converts words to decimal ASCII text.
// A queue-fed request driver, a text monitor and a predictor of the expected characters.
// Depends on b2da_pkg and the binary_to_decimal_ascii top level.
module binary_to_decimal_ascii_tb;

	import b2da_pkg::*;

	// Width of the converted word, matching the default of the block.
	localparam int WORD_BITS = 32;
	// The most digits one word can produce; a sign may come on top.
	localparam int MAX_DIGITS = 10;
	// Number of random requests after the directed ones.
	localparam int RANDOM_REQUESTS = 260;
	// Cycles without any transfer on either channel before the run is abandoned.
	localparam int STALL_LIMIT = 2000;
	// Length of the single long output hold-off, in cycles.
	localparam int HOLD_OFF_CYCLES = 150;
	// Requests sent before the long hold-off starts.
	localparam int HOLD_OFF_AFTER = 30;
	// Settling time after the last character.
	localparam int DRAIN_CYCLES = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic txt_valid;
	logic txt_stall = 1'b0;
	txt_t txt;

	// Requests waiting to be offered, and the characters that must still arrive.
	req_t pending_req[$];
	txt_t expected_text[$];

	int total_requests = 0;
	int sent_count = 0;
	int accepted_count = 0;
	int negative_count = 0;
	int char_count = 0;
	int error_count = 0;
	int hold_left = 0;
	logic hold_done = 1'b0;
	int quiet_cycles = 0;

	binary_to_decimal_ascii #(
		.VALUE_BITS(WORD_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.txt_valid(txt_valid),
		.txt_stall(txt_stall),
		.txt(txt)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Works out the text of one accepted request and appends it to the expected characters.
	// A set signed flag with the top bit high gives a minus sign and the two's complement
	// magnitude; the most negative word wraps round to its true magnitude of 2^31.
	function automatic void predict_text(input req_t r);
		logic [WORD_BITS-1:0] magnitude;
		logic [WORD_BITS-1:0] remainder;
		logic [7:0] digits [MAX_DIGITS];
		logic negative;
		int n;
		txt_t t;
		negative = r.is_signed && r.value[WORD_BITS-1];
		magnitude = negative ? (~r.value + 1'b1) : r.value;
		n = 0;
		// A zero magnitude still yields one digit, a lone '0'.
		do begin
			remainder = magnitude % 10;
			digits[n] = CH_ZERO + remainder[7:0];
			magnitude = magnitude / 10;
			n++;
		end while (magnitude != 0);
		if (negative) begin
			t.character = CH_MINUS;
			t.last = 1'b0;
			expected_text.push_back(t);
			negative_count++;
		end
		for (int i = n - 1; i >= 0; i--) begin
			t.character = digits[i];
			t.last = (i == 0);
			expected_text.push_back(t);
		end
	endfunction

	function automatic void queue_request(input logic [WORD_BITS-1:0] value, input logic is_signed);
		req_t r;
		r.value = value;
		r.is_signed = is_signed;
		pending_req.push_back(r);
		total_requests++;
	endfunction

	// Idle percentages follow the progress of the sender: first the sender idles less
	// than the receiver, then the other way round, and the final stretch runs flat out.
	function automatic int sender_idle_pct();
		if (sent_count < 100) begin
			return 28;
		end else if (sent_count < 200) begin
			return 51;
		end
		return 0;
	endfunction

	function automatic int receiver_idle_pct();
		if (sent_count < 100) begin
			return 51;
		end else if (sent_count < 200) begin
			return 28;
		end
		return 0;
	endfunction

	// Request driver. A stalled request is held unchanged; otherwise the next pending
	// request is offered unless the sender chooses to idle this cycle. The sender never
	// idles while the receiver is in its long hold-off, so the block fills and stalls.
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && !req_stall) begin
				predict_text(req);
				accepted_count++;
			end
			if (!(req_valid && req_stall)) begin
				if (pending_req.size() != 0 &&
					(hold_left != 0 || $urandom_range(0, 99) >= sender_idle_pct())) begin
					req <= pending_req.pop_front();
					req_valid <= 1'b1;
					sent_count <= sent_count + 1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Text monitor. Every accepted character is compared with the oldest expected one.
	// The output stall is random, apart from one long hold-off counted down here.
	always @(posedge clk) begin
		txt_t want;
		if (!arst_n) begin
			txt_stall <= 1'b0;
		end else begin
			if (txt_valid && !txt_stall) begin
				char_count++;
				if (expected_text.size() == 0) begin
					$error("character %h with last %b arrived while none was expected",
						txt.character, txt.last);
					error_count++;
				end else begin
					want = expected_text.pop_front();
					if (txt.character !== want.character) begin
						$error("character: expected %h, actual %h", want.character,
							txt.character);
						error_count++;
					end
					if (txt.last !== want.last) begin
						$error("last: expected %b, actual %b", want.last, txt.last);
						error_count++;
					end
				end
			end
			if (hold_left != 0) begin
				txt_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (!hold_done && sent_count >= HOLD_OFF_AFTER) begin
				txt_stall <= 1'b1;
				hold_left <= HOLD_OFF_CYCLES;
				hold_done <= 1'b1;
			end else begin
				txt_stall <= ($urandom_range(0, 99) < receiver_idle_pct());
			end
		end
	end

	// Watchdog: any cycle with a transfer on either channel restarts the count.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (txt_valid && !txt_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		logic [WORD_BITS-1:0] value;

		// Directed requests: zero both ways, digit count boundaries, the top bit with
		// and without the signed flag, and the most negative word.
		queue_request(32'd0, 1'b0);
		queue_request(32'd0, 1'b1);
		queue_request(32'd1, 1'b1);
		queue_request(32'd9, 1'b0);
		queue_request(32'd10, 1'b0);
		queue_request(32'd99, 1'b1);
		queue_request(32'd100, 1'b0);
		queue_request(32'd999999999, 1'b0);
		queue_request(32'd1000000000, 1'b1);
		queue_request(32'hFFFF_FFFF, 1'b0);
		queue_request(32'hFFFF_FFFF, 1'b1);
		queue_request(32'h8000_0000, 1'b1);
		queue_request(32'h8000_0000, 1'b0);
		queue_request(32'h7FFF_FFFF, 1'b1);
		queue_request(32'h7FFF_FFFF, 1'b0);
		queue_request(32'hFFFF_FFF6, 1'b1);
		queue_request(32'd4000000000, 1'b0);
		queue_request(32'h8000_0001, 1'b1);
		queue_request(32'hAAAA_AAAA, 1'b0);
		queue_request(32'h5555_5555, 1'b1);

		// Random requests: full words, short ones, words of random width and small
		// negative numbers, each with a random signed flag.
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			case ($urandom_range(0, 3))
				0: begin
					value = $urandom;
				end
				1: begin
					value = $urandom_range(0, 99);
				end
				2: begin
					value = $urandom >> $urandom_range(0, WORD_BITS - 1);
				end
				default: begin
					value = -$urandom_range(1, 1000);
				end
			endcase
			queue_request(value, 1'($urandom_range(0, 1)));
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_count < total_requests) begin
			@(posedge clk);
		end
		while (expected_text.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Converted %0d requests into %0d characters, %0d of them negative.",
			accepted_count, char_count, negative_count);
		$display("Both channels idled in turn, and the output was held off for %0d cycles once.",
			HOLD_OFF_CYCLES);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
